>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; every use names its own clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ewg_pkg.sv
// Shared types, codes and constants of the electrode waveform generator.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
package ewg_pkg;

  localparam int DEF_MAX_ELECTRODES    = 8;
  localparam int DEF_SINE_QUARTER_BITS = 8;

  localparam int ELEC_W     = 3;
  localparam int TICK_W     = 32;
  localparam int MODE_W     = 2;
  localparam int AMP_W      = 16;
  localparam int FREQ_W     = 32;
  localparam int DUTY_W     = 16;
  localparam int VOLT_W     = 17;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SINE_W     = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [SINE_W-1:0] SINE_PEAK = 16'd32767;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELECTRODE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_AMPLITUDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_BIAS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_FREQUENCY = 3'd5;

  // Request commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Waveform modes (table entries and legacy register)
  localparam logic [MODE_W-1:0] MODE_DC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PULSE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd3;

  typedef logic signed [AMP_W-1:0]  amp_t;
  typedef logic signed [VOLT_W-1:0] volt_t;

  // What the back end has to do with a request
  typedef enum logic [1:0] {
    OP_ZERO,
    OP_CONST,
    OP_SINE,
    OP_PULSE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              err;
    amp_t              amp;
    amp_t              bias;
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] offs;
    logic [DUTY_W-1:0] duty;
    logic [TICK_W-1:0] tick;
  } ewg_item_t;

  // Quarter-wave sine entry i of a 2^bits table, Q1.15, from a degree-9 odd
  // polynomial in Q30. Evaluated at elaboration only.
  function automatic logic [SINE_W-1:0] quarter_sine(int unsigned i, int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] r;
    x  = 64'(i) << (30 - bits);
    x2 = (x * x) >> 30;
    p  = 64'd5026995 - ((64'd172272 * x2) >> 30);
    p  = 64'd85569306 - ((p * x2) >> 30);
    p  = 64'd693598668 - ((p * x2) >> 30);
    p  = 64'd1686629713 - ((p * x2) >> 30);
    s  = (p * x) >> 30;
    r  = (s * 64'd32767 + 64'd536870912) >> 30;
    return r[SINE_W-1:0];
  endfunction

endpackage

>>> rtl/ewg_if.sv
// Request and result channel interfaces of the electrode waveform generator.
// Depends on ewg_pkg for field widths and types.
interface ewg_in_if;
  import ewg_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [ELEC_W-1:0] electrode;
  logic [TICK_W-1:0] time_tick;
  logic [MODE_W-1:0] wave_mode;
  amp_t              amplitude;
  amp_t              offset_bias;
  logic [FREQ_W-1:0] frequency_word;
  logic [FREQ_W-1:0] phase_offset;
  logic [DUTY_W-1:0] duty_fraction;

  modport source (
    output valid, command, electrode, time_tick, wave_mode, amplitude,
           offset_bias, frequency_word, phase_offset, duty_fraction,
    input  ready
  );
  modport sink (
    input  valid, command, electrode, time_tick, wave_mode, amplitude,
           offset_bias, frequency_word, phase_offset, duty_fraction,
    output ready
  );
endinterface

interface ewg_out_if;
  import ewg_pkg::*;

  logic  valid;
  logic  ready;
  volt_t voltage;
  logic  index_error;

  modport source (output valid, voltage, index_error, input ready);
  modport sink (input valid, voltage, index_error, output ready);
endinterface

>>> rtl/ewg_front.sv
// Front end: configuration registers, electrode table, request classification.
// Depends on ewg_pkg and ewg_in_if; pushes classified requests into ewg_queue.
module ewg_front #(
  parameter int MAX_ELECTRODES = ewg_pkg::DEF_MAX_ELECTRODES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ewg_in_if.sink                             in_ch,
  input  logic                               cfg_we,
  input  logic [ewg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ewg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               q_full,
  output logic                               push,
  output ewg_pkg::ewg_item_t                 push_item
);
  import ewg_pkg::*;

  // Only indexes the electrode field can reach need storage
  localparam int TBL_DEPTH = (MAX_ELECTRODES < (1 << ELEC_W)) ? MAX_ELECTRODES : (1 << ELEC_W);
  localparam int TBL_IDX_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  logic               multi_en_r;
  logic [COUNT_W-1:0] count_r;
  logic [MODE_W-1:0]  lmode_r;
  amp_t               lamp_r;
  amp_t               lbias_r;
  logic [FREQ_W-1:0]  lfreq_r;

  logic [MODE_W-1:0]  mode_tbl_r  [TBL_DEPTH];
  amp_t               amp_tbl_r   [TBL_DEPTH];
  amp_t               bias_tbl_r  [TBL_DEPTH];
  logic [FREQ_W-1:0]  freq_tbl_r  [TBL_DEPTH];
  logic [FREQ_W-1:0]  phase_tbl_r [TBL_DEPTH];
  logic [DUTY_W-1:0]  duty_tbl_r  [TBL_DEPTH];

  logic                 accept;
  logic                 e_lt_max;
  logic                 e_lt_cnt;
  logic                 legacy;
  logic [TBL_IDX_W-1:0] idx;
  logic                 tbl_we;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept;

  assign e_lt_max = int'(in_ch.electrode) < MAX_ELECTRODES;
  assign e_lt_cnt = {1'b0, in_ch.electrode} < count_r;
  assign legacy   = !multi_en_r || (count_r == '0);
  assign idx      = TBL_IDX_W'(in_ch.electrode);
  assign tbl_we   = accept && (in_ch.command == CMD_WRITE) && e_lt_max;

  always_comb begin
    push_item      = '0;
    push_item.op   = OP_ZERO;
    push_item.tick = in_ch.time_tick;
    if (in_ch.command == CMD_WRITE) begin
      push_item.err = !e_lt_max;
    end else if (legacy) begin
      unique case (lmode_r)
        MODE_DC: begin
          push_item.op  = OP_CONST;
          push_item.amp = lamp_r;
        end
        MODE_SINE: begin
          push_item.op   = OP_SINE;
          push_item.amp  = lamp_r;
          push_item.bias = lbias_r;
          push_item.freq = lfreq_r;
        end
        default: push_item.op = OP_ZERO;
      endcase
    end else if (!e_lt_cnt || !e_lt_max) begin
      push_item.err = 1'b1;
    end else begin
      push_item.amp  = amp_tbl_r[idx];
      push_item.bias = bias_tbl_r[idx];
      push_item.freq = freq_tbl_r[idx];
      unique case (mode_tbl_r[idx])
        MODE_DC:    push_item.op = OP_CONST;
        MODE_SINE: begin
          push_item.op   = OP_SINE;
          push_item.offs = phase_tbl_r[idx];
        end
        MODE_PULSE: begin
          push_item.op   = OP_PULSE;
          push_item.duty = duty_tbl_r[idx];
        end
        default:    push_item.op = OP_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      multi_en_r <= 1'b0;
      count_r    <= '0;
      lmode_r    <= '0;
      lamp_r     <= '0;
      lbias_r    <= '0;
      lfreq_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MULTI_ENABLE:     multi_en_r <= cfg_wdata[0];
        CFG_ELECTRODE_COUNT:  count_r    <= cfg_wdata[COUNT_W-1:0];
        CFG_LEGACY_MODE:      lmode_r    <= cfg_wdata[MODE_W-1:0];
        CFG_LEGACY_AMPLITUDE: lamp_r     <= amp_t'(cfg_wdata[AMP_W-1:0]);
        CFG_LEGACY_BIAS:      lbias_r    <= amp_t'(cfg_wdata[AMP_W-1:0]);
        CFG_LEGACY_FREQUENCY: lfreq_r    <= cfg_wdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        mode_tbl_r[i]  <= '0;
        amp_tbl_r[i]   <= '0;
        bias_tbl_r[i]  <= '0;
        freq_tbl_r[i]  <= '0;
        phase_tbl_r[i] <= '0;
        duty_tbl_r[i]  <= '0;
      end
    end else if (tbl_we) begin
      mode_tbl_r[idx]  <= in_ch.wave_mode;
      amp_tbl_r[idx]   <= in_ch.amplitude;
      bias_tbl_r[idx]  <= in_ch.offset_bias;
      freq_tbl_r[idx]  <= in_ch.frequency_word;
      phase_tbl_r[idx] <= in_ch.phase_offset;
      duty_tbl_r[idx]  <= in_ch.duty_fraction;
    end
  end

endmodule

>>> rtl/ewg_queue.sv
// Short request queue between the front end and the evaluation pipeline.
// Depends on ewg_pkg for the request type and depth.
module ewg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ewg_pkg::ewg_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output ewg_pkg::ewg_item_t q_item
);
  import ewg_pkg::*;

  ewg_item_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_PTR_W:0]   cnt_r;

  assign full    = cnt_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ewg_back.sv
// Back end: four-stage evaluation pipeline (phase multiply, sine table read,
// amplitude multiply, scale and bias) ending in the output register.
// Depends on ewg_pkg and ewg_out_if; pops requests from ewg_queue.
module ewg_back #(
  parameter int SINE_QUARTER_BITS = ewg_pkg::DEF_SINE_QUARTER_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ewg_pkg::ewg_item_t q_item,
  output logic               pop,
  ewg_out_if.source          out_ch
);
  import ewg_pkg::*;

  localparam int QLEN = 1 << SINE_QUARTER_BITS;

  // Quarter-wave table, constant contents
  logic [SINE_W-1:0] rom_w [QLEN];

  for (genvar g = 0; g < QLEN; g++) begin : g_rom
    assign rom_w[g] = quarter_sine(g, SINE_QUARTER_BITS);
  end

  logic en1, en2, en3, en_o;

  // Stage 1: phase product
  logic              v1_r;
  op_t               op1_r;
  logic              err1_r;
  amp_t              amp1_r;
  amp_t              bias1_r;
  logic [FREQ_W-1:0] offs1_r;
  logic [DUTY_W-1:0] duty1_r;
  logic [FREQ_W-1:0] prod1_r;
  logic [FREQ_W-1:0] ph_prod;

  // Stage 2: table read and pulse compare
  logic                         v2_r;
  op_t                          op2_r;
  logic                         err2_r;
  amp_t                         amp2_r;
  amp_t                         bias2_r;
  logic [SINE_W-1:0]            rom_r;
  logic                         peak2_r;
  logic                         neg2_r;
  logic                         pulse2_r;
  logic [FREQ_W-1:0]            phase;
  logic [SINE_QUARTER_BITS-1:0] qidx;
  logic [SINE_QUARTER_BITS-1:0] qidx_m;

  // Stage 3: amplitude product
  logic                    v3_r;
  op_t                     op3_r;
  logic                    err3_r;
  amp_t                    bias3_r;
  logic                    pulse3_r;
  volt_t                   sum3_r;
  logic signed [2*AMP_W:0] prod3_r;
  logic [SINE_W-1:0]       mag;
  logic signed [SINE_W:0]  sval;

  // Output stage
  logic                    out_v_r;
  volt_t                   volt_r;
  logic                    err_o_r;
  logic signed [2*AMP_W:0] rnd;
  logic signed [VOLT_W:0]  sine_v;
  volt_t                   volt_nxt;

  assign en_o = !out_v_r || out_ch.ready;
  assign en3  = !v3_r || en_o;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign pop  = q_valid && en1;

  assign ph_prod = q_item.freq * q_item.tick;

  assign phase  = prod1_r + offs1_r;
  assign qidx   = phase[29 -: SINE_QUARTER_BITS];
  assign qidx_m = SINE_QUARTER_BITS'(~qidx + 1'b1);

  assign mag  = peak2_r ? SINE_PEAK : rom_r;
  assign sval = neg2_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Round to nearest, ties up, then drop the Q15 scale
  assign rnd    = prod3_r + 33'sd16384;
  assign sine_v = $signed(rnd[2*AMP_W:15]) + (VOLT_W + 1)'(bias3_r);

  always_comb begin
    case (op3_r)
      OP_CONST: volt_nxt = sum3_r;
      OP_SINE:  volt_nxt = sine_v[VOLT_W-1:0];
      OP_PULSE: volt_nxt = pulse3_r ? sum3_r : VOLT_W'(bias3_r);
      default:  volt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) v1_r <= q_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en_o) out_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r   <= q_item.op;
      err1_r  <= q_item.err;
      amp1_r  <= q_item.amp;
      bias1_r <= q_item.bias;
      offs1_r <= q_item.offs;
      duty1_r <= q_item.duty;
      prod1_r <= ph_prod;
    end
    if (en2) begin
      op2_r    <= op1_r;
      err2_r   <= err1_r;
      amp2_r   <= amp1_r;
      bias2_r  <= bias1_r;
      rom_r    <= rom_w[phase[30] ? qidx_m : qidx];
      peak2_r  <= phase[30] && (qidx == '0);
      neg2_r   <= phase[31];
      pulse2_r <= prod1_r[FREQ_W-1:FREQ_W-DUTY_W] < duty1_r;
    end
    if (en3) begin
      op3_r    <= op2_r;
      err3_r   <= err2_r;
      bias3_r  <= bias2_r;
      pulse3_r <= pulse2_r;
      sum3_r   <= VOLT_W'(amp2_r) + VOLT_W'(bias2_r);
      prod3_r  <= (2*AMP_W+1)'(amp2_r) * (2*AMP_W+1)'(sval);
    end
    if (en_o) begin
      volt_r  <= volt_nxt;
      err_o_r <= err3_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.voltage     = volt_r;
  assign out_ch.index_error = err_o_r;

endmodule

>>> rtl/electrode_waveform_generator_top.sv
// Electrode waveform generator, top level.
// Channels: in_ch carries write or evaluate requests (valid/ready), out_ch
// returns one result per request in request order (valid/ready), and the
// cfg_ write port sets the mode registers; the user must write them only
// while the block is idle, which the block does not enforce. A write stores
// one electrode entry and returns voltage 0; an evaluate returns the DC,
// sine or pulse voltage of the chosen electrode, or the legacy waveform
// when multi-electrode mode is off or the count is zero. Bad indexes return
// voltage 0 with index_error set. A request accepted on in_ch passes the
// queue and the pipeline to out_ch. Throughput: one request per cycle while
// out_ch is not stalled, set by the single pass through the phase
// multiplier, sine table and amplitude multiplier stages. A stalled receiver
// holds the output register; the pipeline and a four-entry queue fill behind
// it, then in_ch.ready drops. Reset (rst_n low, synchronous) clears the
// configuration registers, the electrode table, the queue and all pipeline
// valid bits; the block takes requests in the first cycle after reset.
// Depends on ewg_pkg, ewg_if, ewg_front, ewg_queue and ewg_back.
module electrode_waveform_generator_top #(
  parameter int MAX_ELECTRODES    = ewg_pkg::DEF_MAX_ELECTRODES,
  parameter int SINE_QUARTER_BITS = ewg_pkg::DEF_SINE_QUARTER_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ewg_in_if.sink                         in_ch,
  ewg_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ewg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ewg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ewg_pkg::*;

  logic      push;
  ewg_item_t push_item;
  logic      q_full;
  logic      pop;
  logic      q_valid;
  ewg_item_t q_item;

  ewg_front #(
    .MAX_ELECTRODES (MAX_ELECTRODES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ewg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  ewg_back #(
    .SINE_QUARTER_BITS (SINE_QUARTER_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/ewg_checker.sv
// Port-level checks on the result channel of the waveform generator.
// Depends on ewg_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module ewg_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input ewg_pkg::volt_t voltage,
  input logic           index_error
);
  import ewg_pkg::*;

  `ASSERT_NEXT_ALWAYS(a_reset_empties, clk, !rst_n, !out_valid, "result valid right after reset")
  `ASSERT_NEXT(a_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_payload_holds, clk, rst_n, out_valid && !out_ready, $stable(voltage) && $stable(index_error), "stalled result changed")
  `ASSERT_IMPLIES(a_err_zero_volt, clk, rst_n, out_valid && index_error, voltage == '0, "index error with nonzero voltage")

endmodule

bind electrode_waveform_generator_top ewg_checker u_ewg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .voltage     (out_ch.voltage),
  .index_error (out_ch.index_error)
);
